/* rtl/sfr_pkg.sv */
// shared types and constants for the stream find-and-replace block
// no dependencies
`default_nettype none

package sfr_pkg;

  localparam int MAX_PATTERN_BYTES_DEF = 8;
  localparam int BYTE_W                = 8;
  localparam int CFG_W                 = 64;
  localparam int LEN_W                 = 4;
  localparam int TALLY_W               = 16;
  localparam int CFG_IDX_W             = 3;
  localparam int REPL_MAX              = 8;
  localparam int BYTE_SEL_W            = 3;
  localparam int QUEUE_DEPTH           = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_BYTES     = 3'd0,
    REG_PATTERN_LENGTH    = 3'd1,
    REG_REPLACEMENT_BYTES = 3'd2,
    REG_REPLACEMENT_LENGTH = 3'd3,
    REG_FIRST_ONLY        = 3'd4
  } sfr_reg_t;

  typedef struct packed {
    logic [CFG_W-1:0] pattern_bytes;
    logic [LEN_W-1:0] pattern_length;
    logic [CFG_W-1:0] replacement_bytes;
    logic [LEN_W-1:0] replacement_length;
    logic             first_only;
  } sfr_cfg_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              string_end;
  } sfr_in_t;

  typedef struct packed {
    logic [BYTE_W-1:0]  out_byte;
    logic               byte_valid;
    logic               end_of_result;
    logic [TALLY_W-1:0] replace_count;
  } sfr_out_t;

  // one queued request: bytes to emit, how many, end marker and tally
  typedef struct packed {
    logic [CFG_W-1:0]   data;
    logic [LEN_W-1:0]   byte_cnt;
    logic               last;
    logic [TALLY_W-1:0] tally;
  } sfr_cmd_t;

endpackage

`default_nettype wire

/* rtl/sfr_front.sv */
// front part: byte window, pattern compare and request build
// depends on sfr_pkg
`default_nettype none

module sfr_front #(
  parameter int MAX_PATTERN_BYTES = sfr_pkg::MAX_PATTERN_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  sfr_pkg::sfr_cfg_t cfg,
  input  logic              in_valid,
  input  sfr_pkg::sfr_in_t  in_data,
  input  logic              q_full,
  output logic              push,
  output sfr_pkg::sfr_cmd_t push_cmd
);
  import sfr_pkg::*;

  localparam int FW = $clog2(MAX_PATTERN_BYTES + 1);
  localparam int WW = MAX_PATTERN_BYTES * BYTE_W;
  localparam logic [LEN_W-1:0] MAXL = LEN_W'(MAX_PATTERN_BYTES);
  localparam logic [LEN_W-1:0] RMAXL = LEN_W'(REPL_MAX);

  logic [WW-1:0]      wnd_r, wnd_nxt;
  logic [FW-1:0]      fill_r, fill_nxt;
  logic               done_r, done_nxt;
  logic [TALLY_W-1:0] tally_r, tally_nxt;

  logic                         accept;
  logic [LEN_W-1:0]             fill_w, fill_a, fill_keep;
  logic [LEN_W-1:0]             plen, rlen, eff, k0;
  logic                         may_match, hit, over, at_len;
  logic [MAX_PATTERN_BYTES-1:0] byte_ok;
  logic [WW-1:0]                wnd_app, wnd_sh;
  logic [TALLY_W-1:0]           tally_inc;

  assign accept = in_valid && !q_full;

  always_comb begin
    fill_w    = LEN_W'(fill_r);
    plen      = (cfg.pattern_length > MAXL) ? MAXL : cfg.pattern_length;
    rlen      = (cfg.replacement_length > RMAXL) ? RMAXL : cfg.replacement_length;
    eff       = (plen == '0) ? LEN_W'(1) : plen;
    may_match = (plen != '0) && !(cfg.first_only && done_r);
    fill_a    = (fill_w < MAXL) ? LEN_W'(fill_w + LEN_W'(1)) : fill_w;

    // append the new byte at the fill position
    for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
      wnd_app[i*BYTE_W +: BYTE_W] = (fill_w == LEN_W'(i)) ? in_data.data_byte
                                                          : wnd_r[i*BYTE_W +: BYTE_W];
      byte_ok[i] = (LEN_W'(i) >= eff) ||
                   (wnd_app[i*BYTE_W +: BYTE_W] == cfg.pattern_bytes[i*BYTE_W +: BYTE_W]);
    end

    over   = fill_a > eff;
    at_len = fill_a == eff;
    hit    = at_len && may_match && (&byte_ok);

    priority if (over) begin
      // pattern shrank below the window: two oldest out
      k0        = LEN_W'(2);
      wnd_sh    = wnd_app >> (2 * BYTE_W);
      fill_keep = LEN_W'(fill_a - LEN_W'(2));
    end else if (hit) begin
      k0        = rlen;
      wnd_sh    = wnd_app;
      fill_keep = '0;
    end else if (at_len) begin
      k0        = LEN_W'(1);
      wnd_sh    = wnd_app >> BYTE_W;
      fill_keep = LEN_W'(fill_a - LEN_W'(1));
    end else begin
      k0        = '0;
      wnd_sh    = wnd_app;
      fill_keep = fill_a;
    end

    tally_inc = (hit && (tally_r != '1)) ? TALLY_W'(tally_r + TALLY_W'(1)) : tally_r;

    push_cmd.data     = hit ? cfg.replacement_bytes : CFG_W'(wnd_app);
    push_cmd.byte_cnt = (in_data.string_end && !hit) ? fill_a : k0;
    push_cmd.last     = in_data.string_end;
    push_cmd.tally    = in_data.string_end ? tally_inc : '0;
    push              = accept && ((push_cmd.byte_cnt != '0) || in_data.string_end);

    wnd_nxt   = wnd_r;
    fill_nxt  = fill_r;
    done_nxt  = done_r;
    tally_nxt = tally_r;
    if (accept) begin
      wnd_nxt = wnd_sh;
      if (in_data.string_end) begin
        fill_nxt  = '0;
        done_nxt  = 1'b0;
        tally_nxt = '0;
      end else begin
        fill_nxt  = FW'(fill_keep);
        done_nxt  = done_r || hit;
        tally_nxt = tally_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    wnd_r <= wnd_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r  <= '0;
      done_r  <= 1'b0;
      tally_r <= '0;
    end else begin
      fill_r  <= fill_nxt;
      done_r  <= done_nxt;
      tally_r <= tally_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_fill_below_max: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r < FW'(MAX_PATTERN_BYTES))
    else $error("window fill reached its limit between items");

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_data.string_end |=> (fill_r == '0) && !done_r && (tally_r == '0))
    else $error("string state not cleared after end byte");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_full)
    else $error("request pushed into full queue");
`endif

endmodule

`default_nettype wire

/* rtl/sfr_queue.sv */
// request queue between front and back parts
// depends on sfr_pkg
`default_nettype none

module sfr_queue #(
  parameter int DEPTH = sfr_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  sfr_pkg::sfr_cmd_t push_cmd,
  output logic              full,
  input  logic              pop,
  output sfr_pkg::sfr_cmd_t head_cmd,
  output logic              empty
);
  import sfr_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);

  sfr_cmd_t        mem_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]     count_r, count_nxt;

  assign full     = count_r == (AW+1)'(DEPTH);
  assign empty    = count_r == '0;
  assign head_cmd = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : AW'(wr_ptr_r + AW'(1));
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : AW'(rd_ptr_r + AW'(1));
    end
    unique case ({push, pop})
      2'b10:   count_nxt = (AW+1)'(count_r + (AW+1)'(1));
      2'b01:   count_nxt = (AW+1)'(count_r - (AW+1)'(1));
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (AW+1)'(DEPTH))
    else $error("queue count out of range");
`endif

endmodule

`default_nettype wire

/* rtl/sfr_back.sv */
// back part: walks the head request and emits one result per cycle while out_stall is low
// depends on sfr_pkg
`default_nettype none

module sfr_back (
  input  logic              clk,
  input  logic              rst_n,
  input  sfr_pkg::sfr_cmd_t head_cmd,
  input  logic              q_empty,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output sfr_pkg::sfr_out_t out_data
);
  import sfr_pkg::*;

  logic [LEN_W-1:0] idx_r, idx_nxt;
  logic             out_valid_r, out_valid_nxt;
  sfr_out_t         out_r, out_nxt;

  logic [REPL_MAX-1:0][BYTE_W-1:0] bytes;
  logic                            load, last_item;
  sfr_out_t                        item;

  assign bytes     = head_cmd.data;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    load = !q_empty && (!out_valid_r || !out_stall);

    if (idx_r < head_cmd.byte_cnt) begin
      item.out_byte      = bytes[idx_r[BYTE_SEL_W-1:0]];
      item.byte_valid    = 1'b1;
      item.end_of_result = 1'b0;
      item.replace_count = '0;
    end else begin
      // end marker after the last byte
      item.out_byte      = '0;
      item.byte_valid    = 1'b0;
      item.end_of_result = 1'b1;
      item.replace_count = head_cmd.tally;
    end

    last_item = head_cmd.last ? (idx_r == head_cmd.byte_cnt)
                              : (idx_r == LEN_W'(head_cmd.byte_cnt - LEN_W'(1)));
    pop = load && last_item;

    idx_nxt       = idx_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (load) begin
      idx_nxt       = last_item ? '0 : LEN_W'(idx_r + LEN_W'(1));
      out_nxt       = item;
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_idle_idx: assert property (@(posedge clk) disable iff (!rst_n)
    q_empty |-> idx_r == '0)
    else $error("request index left over with empty queue");

  a_end_no_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.end_of_result |-> !out_r.byte_valid)
    else $error("end marker carries a byte");
`endif

endmodule

`default_nettype wire

/* rtl/stream_find_and_replace.sv */
// stream find-and-replace top level: config registers, front, queue, back
// with an empty queue and a free output, a byte's results pass through the
// request queue entry and the output register before they start on out
// throughput: one byte per cycle while each byte yields at most one result and
// out_stall is low; results leave the output register at one per cycle unless
// stalled, so replacement expansion fills the queue and then stalls the input
// reset: synchronous active-low, clears window fill, tally, queue, output valid and config
`default_nettype none

module stream_find_and_replace #(
  parameter int MAX_PATTERN_BYTES = sfr_pkg::MAX_PATTERN_BYTES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  sfr_pkg::sfr_in_t                in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output sfr_pkg::sfr_out_t               out_data,
  input  logic                            cfg_wr_en,
  input  logic [sfr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sfr_pkg::CFG_W-1:0]       cfg_wdata
);
  import sfr_pkg::*;

  sfr_cfg_t cfg_r, cfg_nxt;
  logic     q_full, q_empty, push, pop;
  sfr_cmd_t push_cmd, head_cmd;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_PATTERN_BYTES:      cfg_nxt.pattern_bytes      = cfg_wdata;
        REG_PATTERN_LENGTH:     cfg_nxt.pattern_length     = cfg_wdata[LEN_W-1:0];
        REG_REPLACEMENT_BYTES:  cfg_nxt.replacement_bytes  = cfg_wdata;
        REG_REPLACEMENT_LENGTH: cfg_nxt.replacement_length = cfg_wdata[LEN_W-1:0];
        REG_FIRST_ONLY:         cfg_nxt.first_only         = cfg_wdata[0];
        default:                cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign in_stall = q_full;

  sfr_front #(
    .MAX_PATTERN_BYTES(MAX_PATTERN_BYTES)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_valid),
    .in_data  (in_data),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  sfr_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .head_cmd (head_cmd),
    .empty    (q_empty)
  );

  sfr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_cmd  (head_cmd),
    .q_empty   (q_empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

/* verif/tb_stream_find_and_replace.sv */
// testbench for stream_find_and_replace: drives byte strings and register writes,
// predicts every result with a scoreboard class and checks each field
// depends on rtl/sfr_pkg.sv and rtl/stream_find_and_replace.sv
`timescale 1ns / 1ps

module tb_stream_find_and_replace;
  import sfr_pkg::*;

  localparam int RANDOM_REQUESTS = 480;
  localparam int SETTLE_CYCLES   = 8;
  localparam int CYCLE_LIMIT     = 500000;

  class replace_scoreboard;
    logic [CFG_W-1:0]  pattern_bytes;
    logic [LEN_W-1:0]  pattern_length;
    logic [CFG_W-1:0]  replacement_bytes;
    logic [LEN_W-1:0]  replacement_length;
    logic              first_only;
    logic [BYTE_W-1:0] window [MAX_PATTERN_BYTES_DEF];
    int unsigned       fill;
    bit                already_hit;
    int unsigned       tally;
    sfr_out_t          pending_results [$];
    int                errors;

    function new();
      pattern_bytes      = '0;
      pattern_length     = '0;
      replacement_bytes  = '0;
      replacement_length = '0;
      first_only         = 1'b0;
      fill               = 0;
      already_hit        = 1'b0;
      tally              = 0;
      errors             = 0;
    endfunction

    function void set_reg(sfr_reg_t idx, logic [CFG_W-1:0] value);
      case (idx)
        REG_PATTERN_BYTES:      pattern_bytes = value;
        REG_PATTERN_LENGTH:     pattern_length = value[LEN_W-1:0];
        REG_REPLACEMENT_BYTES:  replacement_bytes = value;
        REG_REPLACEMENT_LENGTH: replacement_length = value[LEN_W-1:0];
        REG_FIRST_ONLY:         first_only = value[0];
        default: ;
      endcase
    endfunction

    function void push_result(logic [BYTE_W-1:0] b, bit v, bit e, logic [TALLY_W-1:0] cnt);
      sfr_out_t r;
      r.out_byte      = b;
      r.byte_valid    = v;
      r.end_of_result = e;
      r.replace_count = cnt;
      pending_results.push_back(r);
    endfunction

    function void emit_oldest();
      if (fill == 0) return;
      push_result(window[0], 1'b1, 1'b0, '0);
      for (int i = 0; i + 1 < fill; i++) window[i] = window[i + 1];
      fill--;
    endfunction

    function int unsigned pattern_span();
      int unsigned plen;
      plen = (pattern_length > MAX_PATTERN_BYTES_DEF) ? MAX_PATTERN_BYTES_DEF : pattern_length;
      return plen;
    endfunction

    function void note_request(sfr_in_t req);
      int unsigned plen;
      int unsigned rlen;
      int unsigned span;
      bit          may_hit;
      bit          hit;
      plen    = pattern_span();
      rlen    = (replacement_length > REPL_MAX) ? REPL_MAX : replacement_length;
      span    = (plen == 0) ? 1 : plen;
      may_hit = (plen != 0) && !(first_only && already_hit);
      if (fill < MAX_PATTERN_BYTES_DEF) begin
        window[fill] = req.data_byte;
        fill++;
      end
      if (fill > span) begin
        emit_oldest();
        emit_oldest();
      end else if (fill == span) begin
        hit = may_hit;
        for (int i = 0; i < span; i++)
          if (window[i] != pattern_bytes[8*i +: 8]) hit = 1'b0;
        if (hit) begin
          for (int i = 0; i < rlen; i++)
            push_result(replacement_bytes[8*i +: 8], 1'b1, 1'b0, '0);
          fill        = 0;
          already_hit = 1'b1;
          if (tally < 16'hffff) tally++;
        end else begin
          emit_oldest();
        end
      end
      if (req.string_end) begin
        while (fill > 0) emit_oldest();
        push_result('0, 1'b0, 1'b1, tally[TALLY_W-1:0]);
        fill        = 0;
        already_hit = 1'b0;
        tally       = 0;
      end
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_result(sfr_out_t got);
      sfr_out_t want;
      if (pending_results.size() == 0) begin
        report($sformatf("result with nothing pending, out_byte %h", got.out_byte));
        return;
      end
      want = pending_results.pop_front();
      if (got.out_byte !== want.out_byte)
        report($sformatf("out_byte %h, predicted %h", got.out_byte, want.out_byte));
      if (got.byte_valid !== want.byte_valid)
        report($sformatf("byte_valid %b, predicted %b", got.byte_valid, want.byte_valid));
      if (got.end_of_result !== want.end_of_result)
        report($sformatf("end_of_result %b, predicted %b", got.end_of_result,
                         want.end_of_result));
      if (got.replace_count !== want.replace_count)
        report($sformatf("replace_count %0d, predicted %0d", got.replace_count,
                         want.replace_count));
    endtask
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  sfr_in_t              in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  sfr_out_t             out_data;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  replace_scoreboard board = new();
  bit                quiet = 1'b0;
  int                hold = 0;
  int                cycles = 0;
  int                sent_requests = 0;

  stream_find_and_replace DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // result side: check each accepted result, then stall for a random hold unless quiet
  always @(posedge clk) begin
    if (!rst_n) begin
      hold = 0;
    end else if (out_valid && !out_stall) begin
      board.check_result(out_data);
      hold = quiet ? 0 : $urandom_range(3);
    end else if (hold > 0) begin
      hold--;
    end
    out_stall <= (hold != 0);
  end

  task automatic send_request(logic [BYTE_W-1:0] b, bit last);
    int gap;
    gap = quiet ? 0 : $urandom_range(3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= {b, last};
    do @(posedge clk); while (in_stall);
    board.note_request(in_data);
    sent_requests++;
  endtask

  task automatic quiesce();
    in_valid <= 1'b0;
    while (board.pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(sfr_reg_t idx, logic [CFG_W-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    board.set_reg(idx, value);
  endtask

  task automatic configure(logic [CFG_W-1:0] pat, int plen, logic [CFG_W-1:0] rep, int rlen,
                           bit first);
    quiesce();
    write_reg(REG_PATTERN_BYTES, pat);
    write_reg(REG_PATTERN_LENGTH, CFG_W'(plen));
    write_reg(REG_REPLACEMENT_BYTES, rep);
    write_reg(REG_REPLACEMENT_LENGTH, CFG_W'(rlen));
    write_reg(REG_FIRST_ONLY, CFG_W'(first));
    cfg_wr_en <= 1'b0;
  endtask

  // mostly pattern copies and fragments, with some noise bytes
  task automatic send_text(int unsigned n);
    logic [BYTE_W-1:0] text [$];
    int unsigned       span;
    int unsigned       cut;
    span = board.pattern_span();
    if (span == 0) span = 1;
    while (text.size() < n) begin
      case ($urandom_range(9))
        0, 1, 2, 3: for (int k = 0; k < span; k++) text.push_back(board.pattern_bytes[8*k +: 8]);
        4, 5: begin
          cut = $urandom_range(span);
          for (int k = 0; k < cut; k++) text.push_back(board.pattern_bytes[8*k +: 8]);
        end
        6: text.push_back(BYTE_W'($urandom_range(255)));
        default: text.push_back(board.pattern_bytes[8*$urandom_range(7) +: 8]);
      endcase
    end
    cut = (text.size() > 1 && $urandom_range(7) == 0) ? $urandom_range(1, text.size() - 1) : 0;
    for (int k = 0; k < text.size(); k++) begin
      if (cut != 0 && k == cut) begin
        quiesce();
        write_reg(REG_PATTERN_LENGTH, CFG_W'($urandom_range(15)));
        cfg_wr_en <= 1'b0;
      end
      send_request(text[k], k == text.size() - 1);
    end
  endtask

  function automatic int pick_length();
    case ($urandom_range(5))
      0: return 0;
      1: return 1;
      2: return 8;
      3: return $urandom_range(9, 15);
      default: return $urandom_range(2, 7);
    endcase
  endfunction

  initial begin
    logic [CFG_W-1:0] pat;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // copy mode after reset, byte extremes
    send_request(8'h00, 1'b0);
    send_request(8'hff, 1'b1);

    // every occurrence, multi-byte replacement
    configure(64'h6261, 2, 64'h7a7978, 3, 1'b0);
    send_request(8'h61, 1'b0);
    send_request(8'h62, 1'b0);
    send_request(8'h61, 1'b0);
    send_request(8'h62, 1'b0);
    send_request(8'h78, 1'b1);

    // oversized lengths saturate, full window replaced on the last byte
    pat = 64'h80ff_7f01_0055_aa10;
    configure(pat, 15, 64'hffee_ddcc_bbaa_9988, 12, 1'b0);
    for (int k = 0; k < 8; k++) send_request(pat[8*k +: 8], k == 7);

    // first occurrence only, deletion
    configure(64'h41, 1, 64'h0, 0, 1'b1);
    send_request(8'h41, 1'b0);
    send_request(8'h41, 1'b0);
    send_request(8'h41, 1'b1);

    // pattern shrunk while the window holds more bytes
    configure(64'h4433_2211, 4, 64'h99, 1, 1'b0);
    send_request(8'h11, 1'b0);
    send_request(8'h22, 1'b0);
    send_request(8'h33, 1'b0);
    quiesce();
    write_reg(REG_PATTERN_LENGTH, CFG_W'(1));
    cfg_wr_en <= 1'b0;
    send_request(8'h11, 1'b0);
    send_request(8'h11, 1'b0);
    send_request(8'h11, 1'b1);

    while (sent_requests < RANDOM_REQUESTS) begin
      quiet = ($urandom_range(4) == 0);
      configure({$urandom, $urandom}, pick_length(), {$urandom, $urandom}, pick_length(),
                1'($urandom_range(1)));
      repeat ($urandom_range(2, 5)) send_text($urandom_range(1, 24));
    end

    quiesce();
    if (board.errors == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
